### rtl/pvfsq_pkg.sv
// ----------------------------------------------------------------------------
// pvfsq_pkg: shared types and constants
// Field widths, status and mode codes, and the command and status structs
// that join the controller to the datapath.
// ----------------------------------------------------------------------------
package pvfsq_pkg;

  localparam int MAX_VOLUMES = 16;
  localparam int IDX_W = (MAX_VOLUMES > 1) ? $clog2(MAX_VOLUMES) : 1;
  localparam int CNT_W = $clog2(MAX_VOLUMES + 1);
  localparam int TOK_W = 48;
  localparam int KEY_W = 64;
  localparam int REQ_W = 32;
  localparam int DIV_STEPS = TOK_W;
  localparam int DCNT_W = $clog2(DIV_STEPS + 1);

  localparam logic [1:0] MODE_CLAIM   = 2'd0;
  localparam logic [1:0] MODE_RELEASE = 2'd1;
  localparam logic [1:0] MODE_SWEEP   = 2'd2;

  localparam logic [1:0] REG_POOL_SIZE   = 2'd0;
  localparam logic [1:0] REG_SHARE_TOTAL = 2'd1;
  localparam logic [1:0] REG_MIN_SHARE   = 2'd2;
  localparam logic [1:0] REG_BALANCE     = 2'd3;

  typedef enum logic [2:0] {
    ST_GRANTED    = 3'd0,
    ST_QUOTA      = 3'd1,
    ST_BELOW_MIN  = 3'd2,
    ST_TABLE_FULL = 3'd3,
    ST_POOL_SHORT = 3'd4,
    ST_UNREG      = 3'd5,
    ST_SWEPT      = 3'd6
  } status_e;

  typedef struct packed {
    logic    ready;
    logic    capture;
    logic    idx_clr;
    logic    idx_inc;
    logic    idx_load;
    logic    scan;
    logic    div_start;
    logic    div_step;
    logic    mul;
    logic    walk;
    logic    reg_new;
    logic    set_fail;
    status_e fail_code;
    logic    fin;
  } cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       bal;
    logic       idx_last;
    logic       hit;
    logic       count_full;
    logic       removed;
    logic       count_nz;
    logic       div_done;
    logic       below_min;
    logic       out_free;
  } sts_t;

endpackage

### rtl/pvfsq_if.sv
// ----------------------------------------------------------------------------
// pvfsq_if: request and result channels
// Valid/ready channels carrying one request item and one result item.
// ----------------------------------------------------------------------------
interface pvfsq_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [63:0] volume_key;
  logic [31:0] request_size;
  modport source (output valid, mode, volume_key, request_size, input ready);
  modport sink (input valid, mode, volume_key, request_size, output ready);
endinterface

interface pvfsq_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [47:0] volume_limit;
  logic [47:0] volume_held;
  logic [47:0] pool_left;
  modport source (output valid, status, volume_limit, volume_held, pool_left, input ready);
  modport sink (input valid, status, volume_limit, volume_held, pool_left, output ready);
endinterface

### rtl/pvfsq_ctrl.sv
// ----------------------------------------------------------------------------
// pvfsq_ctrl: sequencing state machine
// Steps each request through table scan, share division, limit rewrite and
// the final update, issuing commands to the datapath.
// ----------------------------------------------------------------------------
module pvfsq_ctrl import pvfsq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [10:0] {
    S_IDLE   = 11'b00000000001,
    S_DISP   = 11'b00000000010,
    S_SCAN   = 11'b00000000100,
    S_DECIDE = 11'b00000001000,
    S_DIV    = 11'b00000010000,
    S_MUL    = 11'b00000100000,
    S_CHECK  = 11'b00001000000,
    S_WALK   = 11'b00010000000,
    S_LOAD   = 11'b00100000000,
    S_REG    = 11'b01000000000,
    S_FIN    = 11'b10000000000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    cmd_o = '0;
    cmd_o.fail_code = ST_GRANTED;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        cmd_o.ready = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          cmd_o.idx_clr = 1'b1;
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        if (sts_i.mode == MODE_SWEEP ||
            (sts_i.bal && (sts_i.mode == MODE_CLAIM || sts_i.mode == MODE_RELEASE))) begin
          state_d = S_SCAN;
        end else begin
          state_d = S_FIN;
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        cmd_o.idx_inc = 1'b1;
        if (sts_i.idx_last) begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (sts_i.mode == MODE_SWEEP) begin
          if (sts_i.removed && sts_i.count_nz) begin
            cmd_o.div_start = 1'b1;
            state_d = S_DIV;
          end else begin
            state_d = S_FIN;
          end
        end else if (sts_i.hit) begin
          state_d = S_LOAD;
        end else if (sts_i.mode == MODE_RELEASE) begin
          state_d = S_FIN;
        end else if (sts_i.count_full) begin
          cmd_o.set_fail = 1'b1;
          cmd_o.fail_code = ST_TABLE_FULL;
          state_d = S_FIN;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        if (sts_i.div_done) begin
          state_d = S_MUL;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d = S_CHECK;
      end
      S_CHECK: begin
        if (sts_i.mode != MODE_SWEEP && sts_i.below_min) begin
          cmd_o.set_fail = 1'b1;
          cmd_o.fail_code = ST_BELOW_MIN;
          state_d = S_FIN;
        end else begin
          cmd_o.idx_clr = 1'b1;
          state_d = S_WALK;
        end
      end
      S_WALK: begin
        cmd_o.walk = 1'b1;
        cmd_o.idx_inc = 1'b1;
        if (sts_i.idx_last) begin
          state_d = (sts_i.mode == MODE_SWEEP) ? S_FIN : S_LOAD;
        end
      end
      S_LOAD: begin
        cmd_o.idx_load = 1'b1;
        state_d = sts_i.hit ? S_FIN : S_REG;
      end
      S_REG: begin
        cmd_o.reg_new = 1'b1;
        state_d = S_FIN;
      end
      S_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.fin = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

### rtl/pvfsq_dp.sv
// ----------------------------------------------------------------------------
// pvfsq_dp: quota datapath
// Volume table, token pool, configuration registers, serial share divider
// and the result register.
// ----------------------------------------------------------------------------
module pvfsq_dp import pvfsq_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cmd_t             cmd_i,
  output sts_t             sts_o,
  input  logic [1:0]       in_mode_i,
  input  logic [KEY_W-1:0] in_key_i,
  input  logic [REQ_W-1:0] in_size_i,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [TOK_W-1:0] cfg_data_i,
  input  logic             out_ready_i,
  output logic             out_valid_o,
  output logic [2:0]       out_status_o,
  output logic [TOK_W-1:0] out_limit_o,
  output logic [TOK_W-1:0] out_held_o,
  output logic [TOK_W-1:0] out_pool_o
);

  logic [TOK_W-1:0] pool_size_q, share_total_q, min_share_q, pool_q;
  logic             bal_q;

  logic [1:0]       mode_q;
  logic [KEY_W-1:0] key_q;
  logic [REQ_W-1:0] size_q;

  logic [MAX_VOLUMES-1:0] valid_q;
  logic [KEY_W-1:0]       key_mem   [MAX_VOLUMES];
  logic [TOK_W-1:0]       held_mem  [MAX_VOLUMES];
  logic [TOK_W-1:0]       limit_mem [MAX_VOLUMES];
  logic [CNT_W-1:0]       count_q;

  logic [IDX_W-1:0] idx_q, slot_q, free_q;
  logic             hit_q, free_found_q, removed_q, first_q, fail_q;
  status_e          fail_code_q;

  logic [CNT_W-1:0]  dvs_q, rem_q;
  logic [TOK_W-1:0]  quo_q, prod_q;
  logic [DCNT_W-1:0] dcnt_q;
  logic [CNT_W:0]    div_trial;
  logic              div_ge;
  logic [CNT_W+TOK_W-1:0] prod_w;
  logic [TOK_W-1:0]  mine_w;

  logic             out_valid_q;
  status_e          out_status_q;
  logic [TOK_W-1:0] out_limit_q, out_held_q, out_pool_q;

  logic             cur_valid;
  logic [KEY_W-1:0] cur_key;
  logic [TOK_W-1:0] cur_held, cur_lim;
  logic             is_sweep, idx_last;

  status_e          fin_status;
  logic [TOK_W-1:0] fin_limit, fin_held, fin_pool, new_held, rel_diff;
  logic             held_we;
  logic [TOK_W:0]   claim_sum;

  assign cur_valid  = valid_q[idx_q];
  assign cur_key    = key_mem[idx_q];
  assign cur_held   = held_mem[idx_q];
  assign cur_lim    = limit_mem[idx_q];
  assign is_sweep   = (mode_q == MODE_SWEEP);
  assign idx_last   = (idx_q == IDX_W'(MAX_VOLUMES - 1));

  assign div_trial = {rem_q, quo_q[TOK_W-1]};
  assign div_ge    = (div_trial >= {1'b0, dvs_q});
  assign prod_w    = (dvs_q - CNT_W'(1)) * quo_q;
  assign mine_w    = share_total_q - prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_size_q   <= '0;
      share_total_q <= '0;
      min_share_q   <= '0;
      bal_q         <= 1'b0;
      pool_q        <= '0;
    end else begin
      if (cmd_i.fin) begin
        pool_q <= fin_pool;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_POOL_SIZE: begin
            pool_size_q <= cfg_data_i;
            pool_q      <= cfg_data_i;
          end
          REG_SHARE_TOTAL: share_total_q <= cfg_data_i;
          REG_MIN_SHARE:   min_share_q   <= cfg_data_i;
          REG_BALANCE:     bal_q         <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      mode_q <= in_mode_i;
      key_q  <= in_key_i;
      size_q <= in_size_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q      <= '0;
      count_q      <= '0;
      idx_q        <= '0;
      slot_q       <= '0;
      free_q       <= '0;
      hit_q        <= 1'b0;
      free_found_q <= 1'b0;
      removed_q    <= 1'b0;
      first_q      <= 1'b0;
      fail_q       <= 1'b0;
      fail_code_q  <= ST_GRANTED;
    end else begin
      if (cmd_i.capture) begin
        hit_q        <= 1'b0;
        free_found_q <= 1'b0;
        removed_q    <= 1'b0;
        fail_q       <= 1'b0;
      end
      if (cmd_i.idx_clr) begin
        idx_q   <= '0;
        first_q <= 1'b1;
      end else if (cmd_i.idx_inc) begin
        idx_q <= idx_last ? '0 : idx_q + IDX_W'(1);
      end else if (cmd_i.idx_load) begin
        idx_q <= hit_q ? slot_q : free_q;
      end
      if (cmd_i.scan) begin
        if (is_sweep) begin
          if (cur_valid && cur_held == '0) begin
            valid_q[idx_q] <= 1'b0;
            count_q        <= count_q - CNT_W'(1);
            removed_q      <= 1'b1;
          end
        end else begin
          if (cur_valid && cur_key == key_q && !hit_q) begin
            hit_q  <= 1'b1;
            slot_q <= idx_q;
          end
          if (!cur_valid && !free_found_q) begin
            free_found_q <= 1'b1;
            free_q       <= idx_q;
          end
        end
      end
      if (cmd_i.walk && cur_valid) begin
        first_q <= 1'b0;
      end
      if (cmd_i.reg_new) begin
        valid_q[idx_q] <= 1'b1;
        count_q        <= count_q + CNT_W'(1);
        hit_q          <= 1'b1;
      end
      if (cmd_i.set_fail) begin
        fail_q      <= 1'b1;
        fail_code_q <= cmd_i.fail_code;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.walk && cur_valid) begin
      limit_mem[idx_q] <= (is_sweep && first_q) ? mine_w : quo_q;
    end
    if (cmd_i.reg_new) begin
      key_mem[idx_q]   <= key_q;
      held_mem[idx_q]  <= '0;
      limit_mem[idx_q] <= mine_w;
    end
    if (cmd_i.fin && held_we) begin
      held_mem[idx_q] <= new_held;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dcnt_q <= '0;
    end else if (cmd_i.div_start) begin
      dcnt_q <= DCNT_W'(DIV_STEPS);
    end else if (cmd_i.div_step) begin
      dcnt_q <= dcnt_q - DCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      dvs_q <= is_sweep ? count_q : count_q + CNT_W'(1);
      rem_q <= '0;
      quo_q <= share_total_q;
    end else if (cmd_i.div_step) begin
      rem_q <= div_ge ? CNT_W'(div_trial - {1'b0, dvs_q}) : div_trial[CNT_W-1:0];
      quo_q <= {quo_q[TOK_W-2:0], div_ge};
    end
    if (cmd_i.mul) begin
      prod_q <= prod_w[TOK_W-1:0];
    end
  end

  always_comb begin
    fin_status = ST_GRANTED;
    fin_limit  = '0;
    fin_held   = '0;
    fin_pool   = pool_q;
    held_we    = 1'b0;
    new_held   = cur_held;
    claim_sum  = {1'b0, cur_held} + (TOK_W+1)'(size_q);
    rel_diff   = pool_size_q - pool_q;
    case (mode_q)
      MODE_CLAIM: begin
        if (fail_q) begin
          fin_status = fail_code_q;
        end else if (bal_q && claim_sum > {1'b0, cur_lim}) begin
          fin_status = ST_QUOTA;
          fin_limit  = cur_lim;
          fin_held   = cur_held;
        end else begin
          if (bal_q) begin
            fin_limit = cur_lim;
            fin_held  = cur_held;
          end
          if (TOK_W'(size_q) > pool_q) begin
            fin_status = ST_POOL_SHORT;
          end else begin
            fin_pool = pool_q - TOK_W'(size_q);
            if (bal_q) begin
              held_we  = 1'b1;
              new_held = claim_sum[TOK_W-1:0];
              fin_held = claim_sum[TOK_W-1:0];
            end
          end
        end
      end
      MODE_RELEASE: begin
        if (bal_q) begin
          if (hit_q) begin
            held_we   = 1'b1;
            new_held  = (cur_held >= TOK_W'(size_q)) ? cur_held - TOK_W'(size_q) : '0;
            fin_limit = cur_lim;
            fin_held  = new_held;
          end else begin
            fin_status = ST_UNREG;
          end
        end
        fin_pool = (rel_diff < TOK_W'(size_q)) ? pool_size_q : pool_q + TOK_W'(size_q);
      end
      default: begin
        fin_status = ST_SWEPT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.fin) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fin) begin
      out_status_q <= fin_status;
      out_limit_q  <= fin_limit;
      out_held_q   <= fin_held;
      out_pool_q   <= fin_pool;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_limit_o  = out_limit_q;
  assign out_held_o   = out_held_q;
  assign out_pool_o   = out_pool_q;

  always_comb begin
    sts_o.mode       = mode_q;
    sts_o.bal        = bal_q;
    sts_o.idx_last   = idx_last;
    sts_o.hit        = hit_q;
    sts_o.count_full = (count_q == CNT_W'(MAX_VOLUMES));
    sts_o.removed    = removed_q;
    sts_o.count_nz   = (count_q != '0);
    sts_o.div_done   = (dcnt_q == '0);
    sts_o.below_min  = (mine_w < min_share_q);
    sts_o.out_free   = !out_valid_q || out_ready_i;
  end

endmodule

### rtl/per_volume_fair_share_quota.sv
// ----------------------------------------------------------------------------
// per_volume_fair_share_quota: per-volume fair-share token quota
// Top level joining the controller and the datapath to the channels.
// ----------------------------------------------------------------------------
// The block takes one request at a time and returns one result transfer for
// it. A claim or release with balancing on walks the 16-entry volume table
// one entry a cycle; a claim that registers a new volume adds a serial
// share divider and a second table walk to rewrite the limits; a sweep that
// removes a volume while others remain also runs the divider and the second
// walk, and one that removes none only scans the table. Claims and releases
// with balancing off skip the table. A finished result waits in an output register.
module per_volume_fair_share_quota import pvfsq_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  pvfsq_in_if.sink          in_i,
  pvfsq_out_if.source       out_o,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [TOK_W-1:0]  cfg_data_i
);

  cmd_t cmd;
  sts_t sts;

  assign in_i.ready = cmd.ready;

  pvfsq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pvfsq_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .in_mode_i    (in_i.mode),
    .in_key_i     (in_i.volume_key),
    .in_size_i    (in_i.request_size),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .out_ready_i  (out_o.ready),
    .out_valid_o  (out_o.valid),
    .out_status_o (out_o.status),
    .out_limit_o  (out_o.volume_limit),
    .out_held_o   (out_o.volume_held),
    .out_pool_o   (out_o.pool_left)
  );

`ifndef NO_ASSERTIONS
  // A finished request always presents its result transfer.
  a_fin_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.fin |=> out_o.valid) else $error("result not presented after finish");

  // A new volume is only registered while the table has room.
  a_reg_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.reg_new |-> !sts.count_full) else $error("registration into a full table");

  // The divider is never stepped past its last quotient bit.
  a_div_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.div_step |-> !sts.div_done) else $error("divider stepped after completion");
`endif

endmodule
